FILE: src/tga_pkg.sv
package tga_pkg;

	// Result kinds, also used as the op code of queue items
	localparam logic [1:0] K_HDR = 2'd0;
	localparam logic [1:0] K_PIX = 2'd1;
	localparam logic [1:0] K_RAW = 2'd2;
	localparam logic [1:0] K_ERR = 2'd3;

	// Header layout
	localparam logic [4:0] HDR_TYPE_IDX  = 5'd2;
	localparam logic [4:0] HDR_ZERO_END  = 5'd12;
	localparam logic [4:0] HDR_WLO_IDX   = 5'd12;
	localparam logic [4:0] HDR_WHI_IDX   = 5'd13;
	localparam logic [4:0] HDR_HLO_IDX   = 5'd14;
	localparam logic [4:0] HDR_HHI_IDX   = 5'd15;
	localparam logic [4:0] HDR_DEPTH_IDX = 5'd16;
	localparam logic [4:0] HDR_LAST_IDX  = 5'd17;

	localparam logic [7:0] TYPE_RAW  = 8'd2;
	localparam logic [7:0] TYPE_RLE  = 8'd10;
	localparam logic [7:0] DEPTH_24  = 8'd24;
	localparam logic [7:0] DEPTH_32  = 8'd32;
	localparam logic [7:0] RUN_BIAS  = 8'd127;

	// Decoupling queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	// Classified item handed from front to back
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  cnt;      // pixels requested by this pixel (run length or 1)
		logic [7:0]  raw;
		logic [15:0] width;
		logic [15:0] height;
		logic        has_alpha;
		logic        empty;    // header with zero width or height
		logic [31:0] total;    // width * height
		logic [17:0] padded;   // padded row size in bytes
	} item_t;

	// Result as presented on the output channel
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  repeat_res;
		logic [7:0]  raw_byte;
		logic [15:0] width;
		logic [15:0] height;
		logic        has_alpha;
		logic        last;
	} res_t;

endpackage

FILE: src/tga_if.sv
interface tga_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_file;

	modport source (output valid, output data_byte, output start_of_file, input ready);
	modport sink (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface tga_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [7:0]  repeat_res;
	logic [7:0]  raw_byte;
	logic [15:0] width;
	logic [15:0] height;
	logic        has_alpha;
	logic        last;

	modport source (output valid, output kind, output red, output green, output blue,
		output alpha, output repeat_res, output raw_byte, output width, output height,
		output has_alpha, output last, input ready);
	modport sink (input valid, input kind, input red, input green, input blue,
		input alpha, input repeat_res, input raw_byte, input width, input height,
		input has_alpha, input last, output ready);
endinterface

FILE: src/tga_front.sv
module tga_front (
	input  logic           clk,
	input  logic           arst_n,
	tga_in_if.sink         stream,
	input  logic           q_full,
	output logic           push,
	output tga_pkg::item_t push_item
);
	import tga_pkg::*;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_RAW    = 3'd1;
	localparam logic [2:0] PH_PKT    = 3'd2;
	localparam logic [2:0] PH_PIX    = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	logic [2:0]  phase_q, phase_d, cur_phase;
	logic [4:0]  idx_q, idx_d;
	logic        ok_q, ok_d;
	logic        rle_q, rle_d;
	logic        alpha_q, alpha_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [31:0] total_q, total_d;
	logic [7:0]  pkt_left_q, pkt_left_d;
	logic        pkt_run_q, pkt_run_d;
	logic [23:0] pix_q, pix_d;
	logic [1:0]  bip_q, bip_d;
	logic [1:0]  lastpos;
	logic [20:0] w24;
	logic [17:0] padded;
	logic        acc;
	logic [7:0]  b;

	assign stream.ready = !q_full;
	assign acc = stream.valid && !q_full;
	assign b = stream.data_byte;

	// Padded row size: 4 * ceil(width * depth / 32)
	assign w24 = {1'b0, width_q, 4'b0000} + {2'b00, width_q, 3'b000} + 21'd31;
	assign padded = alpha_q ? {width_q, 2'b00} : {w24[20:5], 2'b00};
	assign lastpos = alpha_q ? 2'd3 : 2'd2;

	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		ok_d       = ok_q;
		rle_d      = rle_q;
		alpha_d    = alpha_q;
		width_d    = width_q;
		height_d   = height_q;
		total_d    = total_q;
		pkt_left_d = pkt_left_q;
		pkt_run_d  = pkt_run_q;
		pix_d      = pix_q;
		bip_d      = bip_q;
		push       = 1'b0;
		push_item  = '0;

		// restart header parsing on a new file
		if (stream.start_of_file) begin
			phase_d  = PH_HEADER;
			idx_d    = '0;
			ok_d     = 1'b1;
			rle_d    = 1'b0;
			alpha_d  = 1'b0;
			width_d  = '0;
			height_d = '0;
		end
		cur_phase = phase_d;

		case (cur_phase)
			PH_HEADER: begin
				if (idx_d < HDR_ZERO_END) begin
					if (idx_d == HDR_TYPE_IDX) begin
						if (b == TYPE_RAW) rle_d = 1'b0;
						else if (b == TYPE_RLE) rle_d = 1'b1;
						else ok_d = 1'b0;
					end else if (b != 8'd0) begin
						ok_d = 1'b0;
					end
				end else if (idx_d == HDR_WLO_IDX) begin
					width_d[7:0] = b;
				end else if (idx_d == HDR_WHI_IDX) begin
					width_d[15:8] = b;
				end else if (idx_d == HDR_HLO_IDX) begin
					height_d[7:0] = b;
				end else if (idx_d == HDR_HHI_IDX) begin
					height_d[15:8] = b;
				end else if (idx_d == HDR_DEPTH_IDX) begin
					if (b == DEPTH_24) alpha_d = 1'b0;
					else if (b == DEPTH_32) alpha_d = 1'b1;
					else ok_d = 1'b0;
					total_d = width_q * height_q;
				end

				if (idx_d < HDR_LAST_IDX) begin
					idx_d = idx_d + 5'd1;
				end else if (!ok_d) begin
					push           = 1'b1;
					push_item.kind = K_ERR;
					phase_d        = PH_DONE;
				end else begin
					push                = 1'b1;
					push_item.kind      = K_HDR;
					push_item.width     = width_q;
					push_item.height    = height_q;
					push_item.has_alpha = alpha_q;
					push_item.total     = total_q;
					push_item.padded    = padded;
					push_item.empty     = (width_q == 16'd0) || (height_q == 16'd0);
					if (push_item.empty) phase_d = PH_DONE;
					else phase_d = rle_q ? PH_PKT : PH_RAW;
				end
			end
			PH_RAW: begin
				push           = 1'b1;
				push_item.kind = K_RAW;
				push_item.raw  = b;
			end
			PH_PKT: begin
				pkt_run_d  = b[7];
				pkt_left_d = b[7] ? b - RUN_BIAS : b + 8'd1;
				bip_d      = '0;
				pix_d      = '0;
				phase_d    = PH_PIX;
			end
			PH_PIX: begin
				if (bip_q < lastpos) begin
					case (bip_q)
						2'd0:    pix_d[7:0]   = b;
						2'd1:    pix_d[15:8]  = b;
						default: pix_d[23:16] = b;
					endcase
					bip_d = bip_q + 2'd1;
				end else begin
					push            = 1'b1;
					push_item.kind  = K_PIX;
					push_item.blue  = pix_q[7:0];
					push_item.green = pix_q[15:8];
					push_item.red   = alpha_q ? pix_q[23:16] : b;
					push_item.alpha = alpha_q ? b : 8'd0;
					push_item.cnt   = pkt_run_q ? pkt_left_q : 8'd1;
					pkt_left_d      = pkt_run_q ? 8'd0 : pkt_left_q - 8'd1;
					bip_d           = '0;
					pix_d           = '0;
					if (pkt_left_d == 8'd0) phase_d = PH_PKT;
				end
			end
			default: ;
		endcase

		// push only for an accepted byte
		if (!acc) push = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			idx_q      <= '0;
			ok_q       <= 1'b1;
			rle_q      <= 1'b0;
			alpha_q    <= 1'b0;
			width_q    <= '0;
			height_q   <= '0;
			total_q    <= '0;
			pkt_left_q <= '0;
			pkt_run_q  <= 1'b0;
			pix_q      <= '0;
			bip_q      <= '0;
		end else if (acc) begin
			phase_q    <= phase_d;
			idx_q      <= idx_d;
			ok_q       <= ok_d;
			rle_q      <= rle_d;
			alpha_q    <= alpha_d;
			width_q    <= width_d;
			height_q   <= height_d;
			total_q    <= total_d;
			pkt_left_q <= pkt_left_d;
			pkt_run_q  <= pkt_run_d;
			pix_q      <= pix_d;
			bip_q      <= bip_d;
		end
	end

endmodule

FILE: src/tga_fifo.sv
module tga_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tga_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output tga_pkg::item_t item
);
	import tga_pkg::*;

	item_t            mem [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QAW:0]     count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == (QAW+1)'(QDEPTH));
	assign valid   = (count_q != '0);
	assign item    = mem[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

FILE: src/tga_back.sv
module tga_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  tga_pkg::item_t q_item,
	output logic           pop,
	tga_out_if.source      result
);
	import tga_pkg::*;

	logic        done_q, done_d;
	logic [31:0] left_q, left_d;
	logic [15:0] row_q, row_d, row_inc;
	logic [17:0] rowb_q, rowb_d;
	logic [17:0] padded_q, padded_d;
	logic [15:0] height_q, height_d;
	logic        alpha_q, alpha_d;
	logic        out_v_q;
	res_t        out_q, res_d;
	logic        emit, load;
	logic        end_row;
	logic [7:0]  rep;

	assign pop  = q_valid && (!out_v_q || result.ready);
	assign load = pop && emit;

	assign end_row = ({1'b0, rowb_q} + 19'd1) >= {1'b0, padded_q};
	assign row_inc = row_q + 16'd1;
	// clamp the requested count to the pixels still owed
	assign rep = ({24'd0, q_item.cnt} > left_q) ? left_q[7:0] : q_item.cnt;

	always_comb begin
		done_d   = done_q;
		left_d   = left_q;
		row_d    = row_q;
		rowb_d   = rowb_q;
		padded_d = padded_q;
		height_d = height_q;
		alpha_d  = alpha_q;
		res_d    = '0;
		emit     = 1'b0;
		res_d.kind = q_item.kind;

		case (q_item.kind)
			K_HDR: begin
				emit            = 1'b1;
				res_d.width     = q_item.width;
				res_d.height    = q_item.height;
				res_d.has_alpha = q_item.has_alpha;
				res_d.last      = q_item.empty;
				done_d          = q_item.empty;
				left_d          = q_item.total;
				row_d           = '0;
				rowb_d          = '0;
				padded_d        = q_item.padded;
				height_d        = q_item.height;
				alpha_d         = q_item.has_alpha;
			end
			K_ERR: begin
				emit       = 1'b1;
				res_d.last = 1'b1;
				done_d     = 1'b1;
			end
			K_RAW: begin
				if (!done_q) begin
					emit            = 1'b1;
					res_d.raw_byte  = q_item.raw;
					res_d.has_alpha = alpha_q;
					if (end_row) begin
						rowb_d = '0;
						row_d  = row_inc;
						if (row_inc >= height_q) begin
							res_d.last = 1'b1;
							done_d     = 1'b1;
						end
					end else begin
						rowb_d = rowb_q + 18'd1;
					end
				end
			end
			default: begin
				if (!done_q) begin
					emit             = 1'b1;
					res_d.red        = q_item.red;
					res_d.green      = q_item.green;
					res_d.blue       = q_item.blue;
					res_d.alpha      = q_item.alpha;
					res_d.repeat_res = rep;
					res_d.has_alpha  = alpha_q;
					left_d           = left_q - {24'd0, rep};
					if (left_q <= {24'd0, rep}) begin
						res_d.last = 1'b1;
						done_d     = 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b1;
			left_q   <= '0;
			row_q    <= '0;
			rowb_q   <= '0;
			padded_q <= '0;
			height_q <= '0;
			alpha_q  <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (pop) begin
				done_q   <= done_d;
				left_q   <= left_d;
				row_q    <= row_d;
				rowb_q   <= rowb_d;
				padded_q <= padded_d;
				height_q <= height_d;
				alpha_q  <= alpha_d;
			end
			if (load) out_v_q <= 1'b1;
			else if (result.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) out_q <= res_d;
	end

	assign result.valid      = out_v_q;
	assign result.kind       = out_q.kind;
	assign result.red        = out_q.red;
	assign result.green      = out_q.green;
	assign result.blue       = out_q.blue;
	assign result.alpha      = out_q.alpha;
	assign result.repeat_res = out_q.repeat_res;
	assign result.raw_byte   = out_q.raw_byte;
	assign result.width      = out_q.width;
	assign result.height     = out_q.height;
	assign result.has_alpha  = out_q.has_alpha;
	assign result.last       = out_q.last;

`ifndef SYNTHESIS
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		load && res_d.last |=> done_q)
		else $error("last result did not close the image");

	a_left_live: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |-> left_q != 32'd0)
		else $error("image active with no pixels left");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!done_q |-> row_q < height_q)
		else $error("row count ran past image height");

	a_rep_range: assert property (@(posedge clk) disable iff (!arst_n)
		load && q_item.kind == K_PIX |-> rep != 8'd0 && rep <= 8'd128)
		else $error("pixel run length out of range");
`endif

endmodule

FILE: src/tga_stream_decoder_top.sv
// TGA stream decoder.
// stream: one TGA file byte per item (data_byte), start_of_file high on byte 0
//   of each new file; any byte with start_of_file restarts header parsing.
// result: one item per header (kind 0: width, height, has_alpha), per format
//   error (kind 3), per raw image byte (kind 2) or per RLE pixel run (kind 1:
//   red, green, blue, alpha, repeat_res). last marks the item ending the image.
// Throughput: one byte per cycle, sustained while result.ready is high. The front
//   parses the header and RLE packets; a two-entry queue carries classified items
//   to the back, which tracks rows and pixels left and drives the registered output.
// Path: the queue takes a byte's item at the edge that accepts the byte; the back
//   loads it into the output register once that register is free or taken.
// Stall: while result.ready is low the output register holds; the queue fills
//   and stream.ready drops once both queue entries are taken.
// Reset: arst_n clears the parser to the start of a header, empties the queue
//   and the output register. Bytes after the end of an image or an error give
//   no result until the next start_of_file.
module tga_stream_decoder_top (
	input  logic      clk,
	input  logic      arst_n,
	tga_in_if.sink    stream,
	tga_out_if.source result
);
	import tga_pkg::*;

	logic  q_full;
	logic  q_push;
	item_t q_push_item;
	logic  q_pop;
	logic  q_valid;
	item_t q_item;

	// Front: header checks, packet decode, pixel assembly
	tga_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.q_full    (q_full),
		.push      (q_push),
		.push_item (q_push_item)
	);

	// Queue: decouple the input handshake from the output stall
	tga_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.item      (q_item)
	);

	// Back: row and pixel accounting, run clamp, output register
	tga_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.pop     (q_pop),
		.result  (result)
	);

endmodule

FILE: dv/tga_stream_decoder_top_tb.sv
`timescale 1ns / 100ps

module tga_stream_decoder_top_tb;
	import tga_pkg::*;

	// Hold-off lengths and run bounds
	localparam int RAND_ITEMS    = 950;
	localparam int LONG_HOLD     = 160;
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_PRINT     = 100;
	localparam logic [7:0]  NO_BAD   = 8'hFF;
	localparam logic [15:0] BODY_ALL = 16'hFFFF;

	// Decoder parse phases, mirrored in the testbench's own decoder copy
	typedef enum logic [2:0] {PS_HEADER, PS_RAW, PS_PKT, PS_PIX, PS_DONE} parse_state_e;

	// How packet header bytes are chosen for RLE bodies
	typedef enum logic [1:0] {PK_MIXED, PK_RUN128, PK_RAW128, PK_NOISE} pkt_style_e;

	// One directed file: header fields, body shape and the header result read off by eye
	typedef struct packed {
		logic [7:0]  img_type;
		logic [7:0]  depth;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0]  bad_at;    // header byte forced nonzero, NO_BAD for none
		pkt_style_e  style;
		logic [15:0] max_body;
		logic        sof0;      // start_of_file on byte 0
		logic [3:0]  junk;      // bytes sent after the body without start_of_file
		logic [1:0]  exp_kind;
		logic        exp_last;
	} file_row_t;

	localparam int NDIR = 14;
	localparam file_row_t DIR_TAB [NDIR] = '{
		// type     depth     width       height      bad     style      body      sof   junk  kind   last
		// first file with no start_of_file: parsed as a header straight out of reset
		'{TYPE_RLE, DEPTH_24, 16'd2,     16'd2,     NO_BAD, PK_MIXED,  BODY_ALL, 1'b0, 4'd0, K_HDR, 1'b0},
		// row padding, then bytes after the image that must be dropped
		'{TYPE_RAW, DEPTH_24, 16'd1,     16'd2,     NO_BAD, PK_MIXED,  BODY_ALL, 1'b1, 4'd3, K_HDR, 1'b0},
		'{TYPE_RAW, DEPTH_32, 16'd3,     16'd1,     NO_BAD, PK_MIXED,  BODY_ALL, 1'b1, 4'd0, K_HDR, 1'b0},
		// bad image type, bad depth, nonzero reserved bytes
		'{8'd3,     DEPTH_24, 16'd4,     16'd4,     NO_BAD, PK_MIXED,  BODY_ALL, 1'b1, 4'd2, K_ERR, 1'b1},
		'{TYPE_RLE, 8'd16,    16'd4,     16'd4,     NO_BAD, PK_MIXED,  BODY_ALL, 1'b1, 4'd2, K_ERR, 1'b1},
		'{TYPE_RAW, DEPTH_24, 16'd2,     16'd2,     8'd0,   PK_MIXED,  BODY_ALL, 1'b1, 4'd1, K_ERR, 1'b1},
		'{TYPE_RLE, DEPTH_32, 16'd2,     16'd2,     8'd11,  PK_MIXED,  BODY_ALL, 1'b1, 4'd1, K_ERR, 1'b1},
		// empty images end at the header
		'{TYPE_RLE, DEPTH_24, 16'd0,     16'hFFFF,  NO_BAD, PK_MIXED,  BODY_ALL, 1'b1, 4'd2, K_HDR, 1'b1},
		'{TYPE_RAW, DEPTH_32, 16'hFFFF,  16'd0,     NO_BAD, PK_MIXED,  BODY_ALL, 1'b1, 4'd0, K_HDR, 1'b1},
		// run of 128 clamped to the pixels left; raw packet of 128 cut at the last pixel
		'{TYPE_RLE, DEPTH_32, 16'd3,     16'd2,     NO_BAD, PK_RUN128, BODY_ALL, 1'b1, 4'd0, K_HDR, 1'b0},
		'{TYPE_RLE, DEPTH_24, 16'd2,     16'd2,     NO_BAD, PK_RAW128, BODY_ALL, 1'b1, 4'd4, K_HDR, 1'b0},
		// largest sizes, abandoned early by the next start_of_file
		'{TYPE_RLE, DEPTH_32, 16'hFFFF,  16'hFFFF,  NO_BAD, PK_RUN128, 16'd25,   1'b1, 4'd0, K_HDR, 1'b0},
		'{TYPE_RAW, DEPTH_24, 16'hFFFF,  16'd1,     NO_BAD, PK_MIXED,  16'd12,   1'b1, 4'd0, K_HDR, 1'b0},
		'{TYPE_RLE, DEPTH_24, 16'd5,     16'd3,     NO_BAD, PK_NOISE,  BODY_ALL, 1'b1, 4'd0, K_HDR, 1'b0}
	};

	logic clk;
	logic arst_n;

	tga_in_if  in_ch ();
	tga_out_if out_ch ();

	tga_stream_decoder_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (in_ch),
		.result (out_ch)
	);

	// Decoder state as this testbench tracks it
	parse_state_e parse_st;
	logic [4:0]   hdr_idx;
	logic         hdr_good;
	logic         rle_on;
	logic         alpha_on;
	logic [15:0]  img_w;
	logic [15:0]  img_h;
	logic [7:0]   pkt_left;
	logic         pkt_run;
	logic [23:0]  pix_acc;
	logic [1:0]   pix_pos;
	logic [15:0]  col_cnt;
	logic [15:0]  row_cnt;
	logic [17:0]  row_bytes;
	logic [17:0]  row_pad;

	res_t decoded_q [$];    // results still owed by the block, oldest first

	int  err_count;
	int  bytes_used;        // bytes that the decoder acts on; dropped bytes are not counted
	int  files_sent;
	int  stall_cycles;
	int  n_hdr, n_err, n_run, n_raw;
	int  src_mode, snk_mode;
	bit  long_hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run well beyond the slowest legal pace
	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		// keep the log readable on a badly broken block; the count still runs
		if (err_count <= MAX_PRINT)
			$display("%0t ns mismatch: %s", $time, msg);
	endtask

	task automatic cmp_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Idle cycles before the next item: 0 none, 1 always random, else now and then
	function automatic int draw_wait(input int mode);
		case (mode)
			0: return 0;
			1: return int'($urandom_range(0, 11));
			default: return ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 11)) : 0;
		endcase
	endfunction

	// Bias byte values toward the extremes
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void clear_decoder();
		parse_st  = PS_HEADER;
		hdr_idx   = '0;
		hdr_good  = 1'b1;
		rle_on    = 1'b0;
		alpha_on  = 1'b0;
		img_w     = '0;
		img_h     = '0;
		pkt_left  = '0;
		pkt_run   = 1'b0;
		pix_acc   = '0;
		pix_pos   = '0;
		col_cnt   = '0;
		row_cnt   = '0;
		row_bytes = '0;
		row_pad   = '0;
	endfunction

	// Advance the decoder copy by one byte; return the result it causes, if any
	task automatic decode_byte(input logic [7:0] b, input logic sof,
		output bit produced, output res_t r);
		int     bpp;
		int     rep;
		longint px_left;
		longint total;
		logic [1:0] top_pos;
		r = '0;
		produced = 1'b0;
		if (sof)
			clear_decoder();
		case (parse_st)
			PS_HEADER: begin
				if (hdr_idx < HDR_ZERO_END) begin
					if (hdr_idx == HDR_TYPE_IDX) begin
						if (b == TYPE_RAW) rle_on = 1'b0;
						else if (b == TYPE_RLE) rle_on = 1'b1;
						else hdr_good = 1'b0;
					end else if (b != 8'd0) begin
						hdr_good = 1'b0;
					end
				end else if (hdr_idx == HDR_WLO_IDX) img_w[7:0] = b;
				else if (hdr_idx == HDR_WHI_IDX) img_w[15:8] = b;
				else if (hdr_idx == HDR_HLO_IDX) img_h[7:0] = b;
				else if (hdr_idx == HDR_HHI_IDX) img_h[15:8] = b;
				else if (hdr_idx == HDR_DEPTH_IDX) begin
					if (b == DEPTH_24) alpha_on = 1'b0;
					else if (b == DEPTH_32) alpha_on = 1'b1;
					else hdr_good = 1'b0;
				end
				if (hdr_idx < HDR_LAST_IDX) begin
					hdr_idx = hdr_idx + 5'd1;
				end else if (!hdr_good) begin
					r.kind = K_ERR;
					r.last = 1'b1;
					parse_st = PS_DONE;
					produced = 1'b1;
				end else begin
					bpp = alpha_on ? 32 : 24;
					row_pad = 18'(((int'(img_w) * bpp + 31) / 32) * 4);
					r.kind = K_HDR;
					r.width = img_w;
					r.height = img_h;
					r.has_alpha = alpha_on;
					row_cnt = '0;
					col_cnt = '0;
					row_bytes = '0;
					if (img_w == 16'd0 || img_h == 16'd0) begin
						r.last = 1'b1;
						parse_st = PS_DONE;
					end else begin
						parse_st = rle_on ? PS_PKT : PS_RAW;
					end
					produced = 1'b1;
				end
			end
			PS_RAW: begin
				r.kind = K_RAW;
				r.raw_byte = b;
				r.has_alpha = alpha_on;
				produced = 1'b1;
				if (int'(row_bytes) + 1 >= int'(row_pad)) begin
					row_bytes = '0;
					row_cnt = row_cnt + 16'd1;
					if (row_cnt >= img_h) begin
						r.last = 1'b1;
						parse_st = PS_DONE;
					end
				end else begin
					row_bytes = row_bytes + 18'd1;
				end
			end
			PS_PKT: begin
				if (b < 8'd128) begin
					pkt_run = 1'b0;
					pkt_left = b + 8'd1;
				end else begin
					pkt_run = 1'b1;
					pkt_left = b - RUN_BIAS;
				end
				pix_pos = '0;
				pix_acc = '0;
				parse_st = PS_PIX;
			end
			PS_PIX: begin
				top_pos = alpha_on ? 2'd3 : 2'd2;
				if (pix_pos < top_pos) begin
					pix_acc = pix_acc | (24'(b) << (8 * pix_pos));
					pix_pos = pix_pos + 2'd1;
				end else begin
					// stored order is B, G, R(, A)
					r.blue = pix_acc[7:0];
					r.green = pix_acc[15:8];
					if (alpha_on) begin
						r.red = pix_acc[23:16];
						r.alpha = b;
					end else begin
						r.red = b;
						r.alpha = 8'd0;
					end
					px_left = (longint'(img_h) - longint'(row_cnt)) * longint'(img_w)
						- longint'(col_cnt);
					if (pkt_run) begin
						rep = int'(pkt_left);
						if (longint'(rep) > px_left)
							rep = int'(px_left);
						pkt_left = '0;
					end else begin
						rep = 1;
						pkt_left = pkt_left - 8'd1;
					end
					r.kind = K_PIX;
					r.repeat_res = 8'(rep);
					r.has_alpha = alpha_on;
					produced = 1'b1;
					total = longint'(col_cnt) + longint'(rep);
					row_cnt = 16'(longint'(row_cnt) + total / longint'(img_w));
					col_cnt = 16'(total % longint'(img_w));
					pix_pos = '0;
					pix_acc = '0;
					if (px_left <= longint'(rep)) begin
						r.last = 1'b1;
						parse_st = PS_DONE;
					end else if (pkt_left == 8'd0) begin
						parse_st = PS_PKT;
					end
				end
			end
			default: ;
		endcase
	endtask

	// Offer one byte after a drawn gap and hold it until taken. Valid is lowered only
	// when a gap follows, so back-to-back bytes keep it high across the edge.
	task automatic put_byte(input logic [7:0] b, input logic sof, input bit typed,
		input res_t typed_res);
		int   gap;
		bit   produced;
		res_t r;
		gap = draw_wait(src_mode);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data_byte <= b;
		in_ch.start_of_file <= sof;
		do @(posedge clk); while (!in_ch.ready);
		if (sof || parse_st != PS_DONE)
			bytes_used++;
		decode_byte(b, sof, produced, r);
		if (produced)
			decoded_q.push_back(typed ? typed_res : r);
	endtask

	function automatic logic [17:0][7:0] make_header(input logic [7:0] img_type,
		input logic [7:0] depth, input logic [15:0] w, input logic [15:0] h);
		logic [17:0][7:0] hdr;
		hdr = '0;
		hdr[HDR_TYPE_IDX]  = img_type;
		hdr[HDR_WLO_IDX]   = w[7:0];
		hdr[HDR_WHI_IDX]   = w[15:8];
		hdr[HDR_HLO_IDX]   = h[7:0];
		hdr[HDR_HHI_IDX]   = h[15:8];
		hdr[HDR_DEPTH_IDX] = depth;
		hdr[HDR_LAST_IDX]  = 8'($urandom_range(0, 255));   // descriptor, ignored
		return hdr;
	endfunction

	// Send the first hdr_len header bytes, then (for a full header) body bytes shaped by
	// style until the image ends or max_body bytes went out, then the trailing junk.
	task automatic send_file(input logic [17:0][7:0] hdr, input int hdr_len,
		input logic sof0, input pkt_style_e style, input int max_body, input int junk,
		input bit typed, input res_t typed_res);
		int         n;
		int         len;
		logic [7:0] b;
		files_sent++;
		for (int k = 0; k < hdr_len; k++)
			put_byte(hdr[k], (k == 0) ? sof0 : 1'b0, typed && (k == HDR_LAST_IDX), typed_res);
		n = 0;
		while (hdr_len == 18 && parse_st != PS_DONE && n < max_body) begin
			if (parse_st == PS_PKT) begin
				case (style)
					PK_RUN128: b = 8'hFF;
					PK_RAW128: b = 8'h7F;
					PK_NOISE:  b = 8'($urandom_range(0, 255));
					default: begin
						len = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 128))
							: int'($urandom_range(1, 3));
						b = $urandom_range(0, 1) ? 8'(len + 127) : 8'(len - 1);
					end
				endcase
			end else begin
				b = pick_byte();
			end
			put_byte(b, 1'b0, 1'b0, '0);
			n++;
		end
		repeat (junk) put_byte(pick_byte(), 1'b0, 1'b0, '0);
	endtask

	// Drop valid and hold until every owed result has come back, then settle
	task automatic wait_drained();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Result side: draw a stall per result, or the long hold when asked for one
	initial begin : result_sink
		int w;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				w = LONG_HOLD;
			end else begin
				w = draw_wait(snk_mode);
			end
			if (w > 0) begin
				out_ch.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// Compare every taken result against the oldest owed one, field by field
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (in_ch.valid && !in_ch.ready)
			stall_cycles++;
		if (out_ch.valid && out_ch.ready) begin
			got.kind       = out_ch.kind;
			got.red        = out_ch.red;
			got.green      = out_ch.green;
			got.blue       = out_ch.blue;
			got.alpha      = out_ch.alpha;
			got.repeat_res = out_ch.repeat_res;
			got.raw_byte   = out_ch.raw_byte;
			got.width      = out_ch.width;
			got.height     = out_ch.height;
			got.has_alpha  = out_ch.has_alpha;
			got.last       = out_ch.last;
			if (decoded_q.size() == 0) begin
				report_mismatch($sformatf("result kind %0d with nothing owed", got.kind));
			end else begin
				want = decoded_q.pop_front();
				cmp_field("kind", got.kind, want.kind);
				cmp_field("red", got.red, want.red);
				cmp_field("green", got.green, want.green);
				cmp_field("blue", got.blue, want.blue);
				cmp_field("alpha", got.alpha, want.alpha);
				cmp_field("repeat_res", got.repeat_res, want.repeat_res);
				cmp_field("raw_byte", got.raw_byte, want.raw_byte);
				cmp_field("width", got.width, want.width);
				cmp_field("height", got.height, want.height);
				cmp_field("has_alpha", got.has_alpha, want.has_alpha);
				cmp_field("last", got.last, want.last);
				case (want.kind)
					K_HDR: n_hdr++;
					K_ERR: n_err++;
					K_PIX: n_run++;
					default: n_raw++;
				endcase
			end
		end
	end

	initial begin : stimulus
		file_row_t        row;
		res_t             want;
		logic [17:0][7:0] hdr;
		logic [7:0]       ftype, fdepth;
		logic [15:0]      fw, fh;
		pkt_style_e       style;
		int               sel, hlen, max_body, junk, dir_bytes, nfile, idx;
		logic             sof0;

		// Drive every input known from time zero while reset is held
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = '0;
		in_ch.start_of_file = 1'b0;
		out_ch.ready = 1'b0;
		long_hold_req = 1'b0;
		src_mode = 1;
		snk_mode = 1;
		clear_decoder();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed files: the header result is taken from the table, the rest predicted
		foreach (DIR_TAB[i]) begin
			row = DIR_TAB[i];
			hdr = make_header(row.img_type, row.depth, row.w, row.h);
			if (row.bad_at != NO_BAD)
				hdr[row.bad_at] = 8'($urandom_range(1, 255));
			want = '0;
			want.kind = row.exp_kind;
			want.last = row.exp_last;
			if (row.exp_kind == K_HDR) begin
				want.width = row.w;
				want.height = row.h;
				want.has_alpha = (row.depth == DEPTH_32);
			end
			send_file(hdr, 18, row.sof0, row.style, int'(row.max_body), int'(row.junk),
				1'b1, want);
		end
		wait_drained();
		dir_bytes = bytes_used;

		// Random files: mostly well-formed with random content, the rest broken or noise
		nfile = 0;
		while (bytes_used - dir_bytes < RAND_ITEMS) begin
			nfile++;
			src_mode = int'($urandom_range(0, 2));
			snk_mode = int'($urandom_range(0, 2));
			ftype = $urandom_range(0, 1) ? TYPE_RLE : TYPE_RAW;
			fdepth = $urandom_range(0, 1) ? DEPTH_32 : DEPTH_24;
			fw = 16'($urandom_range(1, 6));
			fh = 16'($urandom_range(1, 4));
			if ($urandom_range(0, 15) == 0)
				fw = 16'($urandom_range(7, 24));
			style = ($urandom_range(0, 7) == 0) ? PK_NOISE : PK_MIXED;
			hlen = 18;
			max_body = 1000000;
			junk = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 4)) : 0;
			sof0 = ($urandom_range(0, 31) != 0);
			sel = int'($urandom_range(0, 99));

			// Fill the queue and stall the input: steady bytes against a long hold
			if (nfile == 8 || nfile == 70) begin
				src_mode = 0;
				ftype = TYPE_RAW;
				fdepth = DEPTH_32;
				fw = 16'd6;
				fh = 16'd4;
				sof0 = 1'b1;
				junk = 0;
				sel = 99;
				long_hold_req = 1'b1;
			end

			if (sel < 5) begin
				ftype = 8'($urandom_range(0, 255));       // bad image type, mostly
			end else if (sel < 10) begin
				fdepth = 8'($urandom_range(0, 255));      // bad depth, mostly
			end else if (sel < 21 && sel >= 16) begin
				// empty image, the other dimension anywhere in range
				case ($urandom_range(0, 2))
					0: begin fw = 16'd0; fh = 16'($urandom_range(0, 65535)); end
					1: begin fh = 16'd0; fw = 16'($urandom_range(0, 65535)); end
					default: begin fw = 16'd0; fh = 16'd0; end
				endcase
			end else if (sel >= 21 && sel < 27) begin
				max_body = int'($urandom_range(0, 12));   // abandoned mid-body
			end else if (sel >= 27 && sel < 30) begin
				hlen = int'($urandom_range(1, 17));        // abandoned mid-header
			end else if (sel >= 33 && sel < 35) begin
				ftype = TYPE_RLE;
				fw = 16'($urandom_range(1000, 65535));
				fh = 16'($urandom_range(1000, 65535));
				style = $urandom_range(0, 1) ? PK_RUN128 : PK_MIXED;
				max_body = 40;
			end

			hdr = make_header(ftype, fdepth, fw, fh);
			if (sel >= 10 && sel < 16) begin
				// one reserved byte nonzero
				do idx = int'($urandom_range(0, 11)); while (idx == HDR_TYPE_IDX);
				hdr[idx] = 8'($urandom_range(1, 255));
			end else if (sel >= 30 && sel < 33) begin
				for (int k = 0; k < 18; k++)
					hdr[k] = 8'($urandom_range(0, 255));
				max_body = 8;
			end

			send_file(hdr, hlen, sof0, style, max_body, junk, 1'b0, '0);

			// Pause the sender now and then until the block has caught up
			if (nfile % 30 == 0)
				wait_drained();
		end

		wait_drained();
		$display("Decoded %0d files, %0d bytes acted on; input stalled for %0d cycles.",
			files_sent, bytes_used, stall_cycles);
		$display("Checked %0d headers, %0d format errors, %0d pixel runs, %0d raw bytes.",
			n_hdr, n_err, n_run, n_raw);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
src/tga_pkg.sv
src/tga_if.sv
src/tga_front.sv
src/tga_fifo.sv
src/tga_back.sv
src/tga_stream_decoder_top.sv
dv/tga_stream_decoder_top_tb.sv
